// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the shelf equaliser; clocked on clk, muted in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MSSEQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MSSEQ_NEVER(name, cond, msg) \
    `MSSEQ_ASSERT(name, !(cond), msg)

`endif

// ----- hw/rtl/msseq_pkg.sv -----
package msseq_pkg;

    localparam int COEF_FRAC_BITS   = 30;
    localparam int SAMPLE_FRAC_BITS = 12;
    localparam int NTAPS            = 5;

    // tap order within one coefficient set
    localparam int TAP_B0 = 0;
    localparam int TAP_B1 = 1;
    localparam int TAP_B2 = 2;
    localparam int TAP_A1 = 3;
    localparam int TAP_A2 = 4;

    localparam longint NANO       = 64'sd1000000000;
    localparam longint SCALE_NANO = 64'sd435000000;

    // coefficients in units of 1e-9; rows: low 44.1k, low 48k, high 44.1k, high 48k
    localparam longint NANO_TAB [4][NTAPS] = '{
        '{ 64'sd1003493144, -64'sd1972959803, 64'sd970034006,
           -64'sd1973064490, 64'sd973422462 },
        '{ 64'sd1003208909, -64'sd1975164341, 64'sd972434850,
           -64'sd1975252804, 64'sd975555296 },
        '{ 64'sd1507962850, -64'sd1486283619, 64'sd526067061,
           -64'sd715935742, 64'sd263682034 },
        '{ 64'sd1526907727, -64'sd1626539190, 64'sd579979760,
           -64'sd809555904, 64'sd289904201 }
    };

    typedef logic signed [31:0] coef_t;
    typedef logic [NTAPS-1:0][31:0] coef_set_t;
    typedef coef_set_t [1:0] coef_bank_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } eq_state_t;

    // Q2.30, nearest with ties away from zero; feedback taps come out negated
    function automatic coef_t coef_q(input longint nano, input bit neg);
        longint v;
        longint m;
        v = nano * (longint'(1) << COEF_FRAC_BITS);
        if (neg)
        begin
            v = -v;
        end
        if (v >= 0)
        begin
            m = (v + NANO / 2) / NANO;
        end
        else
        begin
            m = -((-v + NANO / 2) / NANO);
        end
        return coef_t'(m);
    endfunction

    function automatic coef_bank_t build_bank(input bit high);
        coef_bank_t bank;
        for (int r = 0; r < 2; r++)
        begin
            for (int t = 0; t < NTAPS; t++)
            begin
                bank[r][t] = coef_q(NANO_TAB[2 * int'(high) + r][t], t >= TAP_A1);
            end
        end
        return bank;
    endfunction

    localparam coef_bank_t LOW_BANK  = build_bank(1'b0);
    localparam coef_bank_t HIGH_BANK = build_bank(1'b1);
    localparam coef_t      K_REBUILD = coef_q(SCALE_NANO, 1'b0);

endpackage

// ----- hw/rtl/stereo_mid_side_shelf_equalizer.sv -----
// Stereo mid/side shelf equaliser. Each input item is one signed 16-bit
// stereo pair (left in s_tdata[15:0], right in s_tdata[31:16]) plus a
// last-pair flag on s_tlast. The block forms mid = L+R and side = L-R in
// Q20.12, runs mid through a low-shelf biquad, rebuilds each channel as
// 0.435 * (mid +/- side) and runs each through its own high-shelf biquad.
// Results are truncated toward zero and saturated to 16 bits; the flag comes
// back unchanged on m_tlast. All products go through one 32x33-bit
// multiplier and one saturating 64-bit accumulator under a step counter:
// 17 products, with the pipeline drained where one filter waits on the last.
// An item is accepted and then occupies the block through its final step,
// so no new pair is taken until that step is done. The result waits in an
// output register, so the next pair may be taken while it is still unread;
// the block stalls on its final step only if that register is still full.
// Writing cfg_data selects the coefficient set (0: 44.1 kHz, 1: 48 kHz) and
// clears all filter history; it is taken only while the block is idle.
`include "assert_macros.svh"

module stereo_mid_side_shelf_equalizer
    import msseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // left_in [15:0], right_in [31:16]
    input  logic        s_tlast,    // frame_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // left_out [15:0], right_out [31:16]
    output logic        m_tlast,    // last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data    // rate_select
);

    // Issue step of the first product of each group; NTAPS products per biquad.
    localparam int OP_MID_I   = 0;
    localparam int OP_LM_I    = OP_MID_I + NTAPS + 3;   // wait for mid output
    localparam int OP_RM_I    = OP_LM_I + 1;
    localparam int OP_LEFT_I  = OP_RM_I + 3;            // wait for rebuilt left
    localparam int OP_RIGHT_I = OP_LEFT_I + NTAPS;
    localparam int ACC_LAG    = 2;                      // operand reg, product reg
    localparam int FIN_LAG    = ACC_LAG + 1;
    localparam int STEP_OUT_I = OP_RIGHT_I + NTAPS - 1 + FIN_LAG + 1;
    localparam int STEP_W     = $clog2(STEP_OUT_I + 1);

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t OP_MID       = step_t'(OP_MID_I);
    localparam step_t OP_MID_END   = step_t'(OP_MID_I + NTAPS - 1);
    localparam step_t OP_LM        = step_t'(OP_LM_I);
    localparam step_t OP_RM        = step_t'(OP_RM_I);
    localparam step_t OP_LEFT      = step_t'(OP_LEFT_I);
    localparam step_t OP_LEFT_END  = step_t'(OP_LEFT_I + NTAPS - 1);
    localparam step_t OP_RIGHT     = step_t'(OP_RIGHT_I);
    localparam step_t OP_RIGHT_END = step_t'(OP_RIGHT_I + NTAPS - 1);
    localparam step_t STEP_OUT     = step_t'(STEP_OUT_I);
    localparam int    QW           = 65 - COEF_FRAC_BITS;
    localparam int    OW           = 33 - SAMPLE_FRAC_BITS;

    // ---------------------------------------------------------------
    // Arithmetic helpers
    // ---------------------------------------------------------------
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // acc / 2^COEF_FRAC_BITS toward zero, saturated to 32 bits
    function automatic logic signed [31:0] fin32(input logic signed [63:0] a);
        logic          inc;
        logic [QW-1:0] q;
        inc = a[63] && (a[COEF_FRAC_BITS-1:0] != '0);
        q   = {a[63], a[63:COEF_FRAC_BITS]} + QW'(inc);
        if (q[QW-1:31] == '0 || q[QW-1:31] == '1)
        begin
            return q[31:0];
        end
        return q[QW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    // Q20.12 to integer toward zero, saturated to 16 bits
    function automatic logic [15:0] out16(input logic signed [31:0] v);
        logic          inc;
        logic [OW-1:0] q;
        inc = v[31] && (v[SAMPLE_FRAC_BITS-1:0] != '0);
        q   = {v[31], v[31:SAMPLE_FRAC_BITS]} + OW'(inc);
        if (q[OW-1:15] == '0 || q[OW-1:15] == '1)
        begin
            return q[15:0];
        end
        return q[OW-1] ? 16'h8000 : 16'h7fff;
    endfunction

    // integer sample sum to Q20.12, saturated to 32 bits
    function automatic logic signed [31:0] to_q12(input logic signed [16:0] v);
        logic signed [32:0] w;
        w = 33'(v) <<< SAMPLE_FRAC_BITS;
        if (w[32] != w[31])
        begin
            return w[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return w[31:0];
    endfunction

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    eq_state_t state_reg, state_next;
    step_t     step_reg, step_next;
    logic      rate_reg;
    logic      m_tvalid_reg;
    logic      run;
    logic      out_free;
    logic      done;
    logic      in_fire;
    logic      cfg_fire;

    assign out_free = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign cfg_fire = cfg_valid && cfg_ready;

    always_comb
    begin
        s_tready  = 1'b0;
        cfg_ready = 1'b0;
        run       = 1'b0;
        done      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
            end
            ST_RUN:
            begin
                run  = 1'b1;
                done = (step_reg == STEP_OUT) && out_free;
            end
            default:
            begin
                run = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !cfg_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (step_reg == STEP_OUT)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + step_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // ---------------------------------------------------------------
    // Input capture
    // ---------------------------------------------------------------
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic signed [31:0] mx_reg;     // new mid sample
    logic signed [31:0] side_reg;
    logic               last_reg;

    assign left_in  = s_tdata[15:0];
    assign right_in = s_tdata[31:16];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mx_reg   <= to_q12(17'(left_in) + 17'(right_in));
            side_reg <= to_q12(17'(left_in) - 17'(right_in));
            last_reg <= s_tlast;
        end
    end

    // ---------------------------------------------------------------
    // Filter history (cleared by reset and by a rate write) and rebuilt samples lm/rm
    // ---------------------------------------------------------------
    logic signed [31:0] mx1_reg, mx2_reg, my1_reg, my2_reg;
    logic signed [31:0] lx1_reg, lx2_reg, ly1_reg, ly2_reg;
    logic signed [31:0] rx1_reg, rx2_reg, ry1_reg, ry2_reg;
    logic signed [31:0] lm_reg, rm_reg;

    // ---------------------------------------------------------------
    // Shared datapath: operand select -> multiply -> accumulate -> finalise
    // ---------------------------------------------------------------
    logic signed [31:0] opa_reg, opa_next;
    logic signed [32:0] opb_reg, opb_next;
    logic signed [64:0] prod_full;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] fin_y;
    step_t              acc_step;
    step_t              fin_step;
    logic               acc_en;
    logic               acc_first;

    // pick coefficient and sample for the product issued at this step
    always_comb
    begin
        opa_next = '0;
        opb_next = '0;
        case (step_reg)
            OP_MID:
            begin
                opa_next = LOW_BANK[rate_reg][TAP_B0];
                opb_next = 33'(mx_reg);
            end
            OP_MID + step_t'(1):
            begin
                opa_next = LOW_BANK[rate_reg][TAP_B1];
                opb_next = 33'(mx1_reg);
            end
            OP_MID + step_t'(2):
            begin
                opa_next = LOW_BANK[rate_reg][TAP_B2];
                opb_next = 33'(mx2_reg);
            end
            OP_MID + step_t'(3):
            begin
                opa_next = LOW_BANK[rate_reg][TAP_A1];
                opb_next = 33'(my1_reg);
            end
            OP_MID_END:
            begin
                opa_next = LOW_BANK[rate_reg][TAP_A2];
                opb_next = 33'(my2_reg);
            end
            OP_LM:
            begin
                opa_next = K_REBUILD;
                opb_next = 33'(my1_reg) + 33'(side_reg);
            end
            OP_RM:
            begin
                opa_next = K_REBUILD;
                opb_next = 33'(my1_reg) - 33'(side_reg);
            end
            OP_LEFT:
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_B0];
                opb_next = 33'(lm_reg);
            end
            OP_LEFT + step_t'(1):
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_B1];
                opb_next = 33'(lx1_reg);
            end
            OP_LEFT + step_t'(2):
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_B2];
                opb_next = 33'(lx2_reg);
            end
            OP_LEFT + step_t'(3):
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_A1];
                opb_next = 33'(ly1_reg);
            end
            OP_LEFT_END:
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_A2];
                opb_next = 33'(ly2_reg);
            end
            OP_RIGHT:
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_B0];
                opb_next = 33'(rm_reg);
            end
            OP_RIGHT + step_t'(1):
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_B1];
                opb_next = 33'(rx1_reg);
            end
            OP_RIGHT + step_t'(2):
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_B2];
                opb_next = 33'(rx2_reg);
            end
            OP_RIGHT + step_t'(3):
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_A1];
                opb_next = 33'(ry1_reg);
            end
            OP_RIGHT_END:
            begin
                opa_next = HIGH_BANK[rate_reg][TAP_A2];
                opb_next = 33'(ry2_reg);
            end
            default:
            begin
                opa_next = '0;
                opb_next = '0;
            end
        endcase
    end

    assign prod_full = opa_reg * opb_reg;

    // the accumulator works on the product that has passed through prod_reg
    assign acc_step = step_reg - step_t'(ACC_LAG);
    assign fin_step = step_reg - step_t'(FIN_LAG);

    always_comb
    begin
        acc_en    = 1'b0;
        acc_first = 1'b0;
        case (acc_step) inside
            [OP_MID:OP_MID_END], OP_LM, OP_RM, [OP_LEFT:OP_RIGHT_END]:
            begin
                acc_en = run;
            end
            default:
            begin
                acc_en = 1'b0;
            end
        endcase
        case (acc_step) inside
            OP_MID, OP_LM, OP_RM, OP_LEFT, OP_RIGHT:
            begin
                acc_first = 1'b1;
            end
            default:
            begin
                acc_first = 1'b0;
            end
        endcase
    end

    assign fin_y = fin32(acc_reg);

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        prod_reg <= prod_full[63:0];
        if (acc_en)
        begin
            acc_reg <= acc_first ? prod_reg : sat_add64(acc_reg, prod_reg);
        end
        // rebuilt channel samples
        if (run && fin_step == OP_LM)
        begin
            lm_reg <= fin_y;
        end
        if (run && fin_step == OP_RM)
        begin
            rm_reg <= fin_y;
        end
    end

    // finalise each biquad: shift its history and store the new output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 1'b0;
            mx1_reg  <= '0;
            mx2_reg  <= '0;
            my1_reg  <= '0;
            my2_reg  <= '0;
            lx1_reg  <= '0;
            lx2_reg  <= '0;
            ly1_reg  <= '0;
            ly2_reg  <= '0;
            rx1_reg  <= '0;
            rx2_reg  <= '0;
            ry1_reg  <= '0;
            ry2_reg  <= '0;
        end
        else if (cfg_fire)
        begin
            // new rate: drop all history
            rate_reg <= cfg_data[0];
            mx1_reg  <= '0;
            mx2_reg  <= '0;
            my1_reg  <= '0;
            my2_reg  <= '0;
            lx1_reg  <= '0;
            lx2_reg  <= '0;
            ly1_reg  <= '0;
            ly2_reg  <= '0;
            rx1_reg  <= '0;
            rx2_reg  <= '0;
            ry1_reg  <= '0;
            ry2_reg  <= '0;
        end
        else if (run)
        begin
            case (fin_step)
                OP_MID_END:
                begin
                    mx2_reg <= mx1_reg;
                    mx1_reg <= mx_reg;
                    my2_reg <= my1_reg;
                    my1_reg <= fin_y;
                end
                OP_LEFT_END:
                begin
                    lx2_reg <= lx1_reg;
                    lx1_reg <= lm_reg;
                    ly2_reg <= ly1_reg;
                    ly1_reg <= fin_y;
                end
                OP_RIGHT_END:
                begin
                    rx2_reg <= rx1_reg;
                    rx1_reg <= rm_reg;
                    ry2_reg <= ry1_reg;
                    ry1_reg <= fin_y;
                end
                default:
                begin
                    mx1_reg <= mx1_reg;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Output register: holds the result until the sink takes it
    // ---------------------------------------------------------------
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic [31:0] m_tdata_reg;
    logic        m_tlast_reg;

    assign left_out  = out16(ly1_reg);
    assign right_out = out16(ry1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (done)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            m_tdata_reg <= {right_out, left_out};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `MSSEQ_ASSERT(a_accept_starts_run, in_fire |=> (state_reg == ST_RUN && step_reg == '0), "item accepted without starting the sequence")
    `MSSEQ_NEVER(a_step_in_range, step_reg > STEP_OUT, "step counter past final step")
    `MSSEQ_ASSERT(a_result_at_final_step, $rose(m_tvalid) |-> ($past(state_reg) == ST_RUN && $past(step_reg) == STEP_OUT), "result raised outside final step")
    `MSSEQ_ASSERT(a_rate_write_clears, cfg_fire |=> (my1_reg == '0 && ly1_reg == '0 && ry1_reg == '0), "history not cleared by rate write")

endmodule

// ----- tb/sv/shelf_eq_checker.sv -----
`timescale 1ns / 1ps

module shelf_eq_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // left_in [15:0], right_in [31:16]
    input  logic        s_tlast,    // frame_last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // left_out [15:0], right_out [31:16]
    input  logic        m_tlast,    // last_out
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_data,   // rate_select
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        last;
    } eq_pair_t;

    localparam longint Q30_ONE      = 64'sd1 << 30;
    localparam longint Q12_ONE      = 64'sd1 << 12;
    localparam longint NANO_UNIT    = 64'sd1000000000;
    localparam longint REBUILD_NANO = 64'sd435000000;
    localparam longint MAX32        = 64'sd2147483647;
    localparam longint MIN32        = -64'sd2147483648;

    // history rows
    localparam int F_MID   = 0;
    localparam int F_LEFT  = 1;
    localparam int F_RIGHT = 2;

    // b0, b1, b2, a1, a2 in units of 1e-9; row 0 is 44.1 kHz, row 1 is 48 kHz
    localparam longint LOW_NANO [2][5] = '{
        '{ 64'sd1003493144, -64'sd1972959803, 64'sd970034006,
           -64'sd1973064490, 64'sd973422462 },
        '{ 64'sd1003208909, -64'sd1975164341, 64'sd972434850,
           -64'sd1975252804, 64'sd975555296 }
    };
    localparam longint HIGH_NANO [2][5] = '{
        '{ 64'sd1507962850, -64'sd1486283619, 64'sd526067061,
           -64'sd715935742, 64'sd263682034 },
        '{ 64'sd1526907727, -64'sd1626539190, 64'sd579979760,
           -64'sd809555904, 64'sd289904201 }
    };

    logic     rate_48k;
    int       hist_in  [3][2];
    int       hist_out [3][2];
    eq_pair_t expected_pairs [$];

    function automatic longint to_q30(input longint nano);
        longint v;
        v = nano * Q30_ONE;
        if (v >= 0)
        begin
            return (v + NANO_UNIT / 2) / NANO_UNIT;
        end
        return -((-v + NANO_UNIT / 2) / NANO_UNIT);
    endfunction

    function automatic int clamp32(input longint v);
        if (v > MAX32)
        begin
            return int'(MAX32);
        end
        if (v < MIN32)
        begin
            return int'(MIN32);
        end
        return int'(v);
    endfunction

    function automatic longint add_sat64(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    function automatic void clear_history();
        for (int f = 0; f < 3; f++)
        begin
            hist_in[f]  = '{0, 0};
            hist_out[f] = '{0, 0};
        end
    endfunction

    function automatic int run_biquad(input int f, input bit high_shelf, input int x);
        longint taps [5];
        longint acc;
        int     y;
        for (int t = 0; t < 5; t++)
        begin
            taps[t] = to_q30(high_shelf ? HIGH_NANO[rate_48k][t] : LOW_NANO[rate_48k][t]);
        end
        acc = taps[0] * x;
        acc = add_sat64(acc, taps[1] * hist_in[f][0]);
        acc = add_sat64(acc, taps[2] * hist_in[f][1]);
        acc = add_sat64(acc, -(taps[3] * hist_out[f][0]));
        acc = add_sat64(acc, -(taps[4] * hist_out[f][1]));
        y = clamp32(acc / Q30_ONE);
        hist_in[f][1]  = hist_in[f][0];
        hist_in[f][0]  = x;
        hist_out[f][1] = hist_out[f][0];
        hist_out[f][0] = y;
        return y;
    endfunction

    function automatic logic [15:0] to_sample16(input int v);
        longint i;
        i = longint'(v) / Q12_ONE;
        if (i > 64'sd32767)
        begin
            i = 64'sd32767;
        end
        if (i < -64'sd32768)
        begin
            i = -64'sd32768;
        end
        return i[15:0];
    endfunction

    function automatic eq_pair_t equalise_pair(input logic [31:0] data, input logic last);
        int       l;
        int       r;
        int       mid;
        int       side;
        int       lm;
        int       rm;
        longint   k;
        eq_pair_t p;
        l    = int'($signed(data[15:0]));
        r    = int'($signed(data[31:16]));
        k    = to_q30(REBUILD_NANO);
        mid  = clamp32(longint'(l + r) * Q12_ONE);
        side = clamp32(longint'(l - r) * Q12_ONE);
        mid  = run_biquad(F_MID, 1'b0, mid);
        lm   = clamp32(k * (longint'(mid) + side) / Q30_ONE);
        rm   = clamp32(k * (longint'(mid) - side) / Q30_ONE);
        p.left  = to_sample16(run_biquad(F_LEFT, 1'b1, lm));
        p.right = to_sample16(run_biquad(F_RIGHT, 1'b1, rm));
        p.last  = last;
        return p;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch: expected %0d (%h), got %0d (%h)", $time, field,
                     $signed(want), want, $signed(got), got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        eq_pair_t want;
        if (!rst_n)
        begin
            rate_48k = 1'b0;
            clear_history();
            expected_pairs.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                rate_48k = cfg_data[0];
                clear_history();
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $display("%0t ns: unexpected result: expected none, got left %h right %h last %b",
                             $time, m_tdata[15:0], m_tdata[31:16], m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    check_field("left_out", want.left, m_tdata[15:0]);
                    check_field("right_out", want.right, m_tdata[31:16]);
                    check_field("last_out", {15'd0, want.last}, {15'd0, m_tlast});
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_pairs.push_back(equalise_pair(s_tdata, s_tlast));
            end
            outstanding = expected_pairs.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    // Rate register codes.
    localparam logic RATE_44K1 = 1'b0;
    localparam logic RATE_48K  = 1'b1;

    // Margin allowed, once every result is in, for the block to fall quiet.
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 204;
    localparam int PHASE_COUNT   = 8;

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } traffic_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;       // left_in [15:0], right_in [31:16]
    logic        s_tlast;       // frame_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;       // left_out [15:0], right_out [31:16]
    logic        m_tlast;       // last_out
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_data;      // rate_select

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches;
    int outstanding;

    always #4 clk = ~clk;

    stereo_mid_side_shelf_equalizer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    shelf_eq_checker pair_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Output side: drop tready at random according to the current stall
    // percentage; a zero percentage holds it high throughout.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic set_traffic(input traffic_t mode);
        case (mode)
            FLOW_FREE:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            FLOW_SRC_IDLE:
            begin
                src_idle_pct   = 61;
                sink_stall_pct = 0;
            end
            FLOW_SINK_STALL:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 61;
            end
            default:
            begin
                src_idle_pct   = 38;
                sink_stall_pct = 38;
            end
        endcase
    endtask

    // Offer one stereo pair and hold it until the block takes it. Idle
    // cycles go in front, so tvalid only drops between items; after the
    // handshake tvalid stays high for the caller to reuse or lower.
    task automatic send_pair(input logic [15:0] left, input logic [15:0] right,
                             input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // Wait until every expected result has arrived, then give the block
    // time to finish any work still in flight. Sample the count on the
    // falling edge, where the checker has settled.
    task automatic wait_drained();
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic rate);
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Sample picker: full range, the corners and one either side of zero,
    // or small values that keep the filters in their linear region.
    function automatic logic [15:0] pick_sample(input int style);
        logic [15:0] corners [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
        case (style)
            1:       return corners[$urandom_range(4)];
            2:       return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // One buffer of pairs ending in the last-pair flag. Most frames carry
    // random content; some drive alternating full scale on mid or side to
    // push the high shelf into saturation; a noisy frame scatters the flag.
    task automatic send_frame(input int len, input bit noisy);
        int          shape;
        logic [15:0] hi_lo;
        logic        last;
        shape = $urandom_range(9);
        for (int i = 0; i < len; i++)
        begin
            last  = noisy ? 1'($urandom) : (i == len - 1);
            hi_lo = (i % 2) ? 16'h8000 : 16'h7FFF;
            if (shape == 8)
            begin
                send_pair(hi_lo, hi_lo, last);
            end
            else if (shape == 9)
            begin
                send_pair(hi_lo, ~hi_lo, last);
            end
            else
            begin
                send_pair(pick_sample(shape < 6 ? 0 : shape - 5),
                          pick_sample($urandom_range(2)), last);
            end
        end
    endtask

    initial
    begin
        int sent;
        int len;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= RATE_44K1;
        set_traffic(FLOW_FREE);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset rate: corners of both channels, then
        // alternating full scale on mid and on side to drive the outputs
        // into both saturation limits.
        send_pair(16'h0000, 16'h0000, 1'b0);
        send_pair(16'h7FFF, 16'h7FFF, 1'b0);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h7FFF, 16'h8000, 1'b0);
        send_pair(16'h8000, 16'h7FFF, 1'b0);
        send_pair(16'h0001, 16'hFFFF, 1'b0);
        send_pair(16'hFFFF, 16'h0001, 1'b1);
        for (int i = 0; i < 12; i++)
        begin
            send_pair((i % 2) ? 16'h8000 : 16'h7FFF, (i % 2) ? 16'h8000 : 16'h7FFF, i == 11);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_pair((i % 2) ? 16'h8000 : 16'h7FFF, (i % 2) ? 16'h7FFF : 16'h8000, i == 3);
        end
        s_tvalid <= 1'b0;

        // Random part: every phase starts from a quiet block with a fresh
        // rate write, and the phases walk through both rates under each
        // traffic pattern.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_drained();
            write_rate((phase % 2) ? RATE_48K : RATE_44K1);
            set_traffic(traffic_t'(phase / 2));
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = $urandom_range(1, 16);
                if (len > PHASE_ITEMS - sent)
                begin
                    len = PHASE_ITEMS - sent;
                end
                send_frame(len, $urandom_range(9) == 0);
                sent += len;
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0)
        begin
            $display("stereo_mid_side_shelf_equalizer regression: pass");
        end
        else
        begin
            $display("stereo_mid_side_shelf_equalizer regression: fail");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs well under this time.
    initial
    begin
        #4_000_000;
        $display("stereo_mid_side_shelf_equalizer regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/msseq_pkg.sv
hw/rtl/stereo_mid_side_shelf_equalizer.sv
tb/sv/shelf_eq_checker.sv
tb/sv/tb.sv
